// ===== rtl/ssq_pkg.sv =====
package ssq_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int KEY_WIDTH_DEF  = 32;

    localparam int KEY_FIELD_W  = 32;
    localparam int SLOT_FIELD_W = 5;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 80;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAIM,
        ST_FREE,
        ST_WALK,
        ST_LINK_A,
        ST_LINK_B,
        ST_POP_RD,
        ST_POP_WR,
        ST_POP_HK,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/ssq_link_mem.sv =====
module ssq_link_mem #(
    parameter int SLOT_COUNT = ssq_pkg::SLOT_COUNT_DEF,
    parameter int SW         = $clog2(SLOT_COUNT + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [SW-1:0] i_waddr,
    input  logic [SW-1:0] i_wdata,
    input  logic [SW-1:0] i_raddr,
    output logic [SW-1:0] o_rdata
);

    localparam int IW = $clog2(SLOT_COUNT);

    logic [SW-1:0]         r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    logic [SW-1:0]         r_mem_q;
    logic [SW-1:0]         r_init_q;
    logic                  r_valid_q;

    // entries never written read as their reset link, slot i -> i+1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr[IW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr[IW-1:0]] <= i_wdata;
        end
        r_mem_q   <= r_mem[i_raddr[IW-1:0]];
        r_init_q  <= i_raddr + SW'(1);
        r_valid_q <= r_valid[i_raddr[IW-1:0]];
    end

    assign o_rdata = r_valid_q ? r_mem_q : r_init_q;

endmodule

// ===== rtl/sorted_slot_list_queue.sv =====
// Sorted slot list queue: an ascending priority queue over SLOT_COUNT slots.
// Input stream (i_s_*): tuser[0] is the request, 0 insert, 1 pop; tdata holds
// the key. Output stream (o_m_*): one result beat per request.
// Insert claims the free-list head, stores the key and walks the active list
// one entry per cycle to link the slot before the first strictly greater key,
// so equal keys leave in arrival order. Pop unlinks the head and frees it.
// Steps from the accepted request to a valid result beat, which ST_DONE builds:
//   insert: ST_CLAIM, ST_FREE, then ST_WALK over up to SLOT_COUNT - 1 entries
//           (skipped on an empty list), one link-memory read per walk step, then ST_LINK_A, ST_LINK_B
//   insert into a full queue or pop of an empty queue: straight to ST_DONE
//   pop:    ST_POP_RD, ST_POP_WR, ST_POP_HK (skipped when the queue becomes empty)
// One request is in flight at a time; o_s_tready is high only while idle.
// A finished result sits in an output register, so the next request is taken
// while the receiver stalls; a second result then waits until that beat goes.
// Reset (synchronous, active low) empties the queue and chains all slots into
// the free list in slot order.
module sorted_slot_list_queue #(
    parameter int SLOT_COUNT = ssq_pkg::SLOT_COUNT_DEF,
    parameter int KEY_WIDTH  = ssq_pkg::KEY_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [31:0] key
    input  logic [ssq_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [0] req_type
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] ok, [5:1] slot, [37:6] popped_key, [42:38] first_slot,
    // [74:43] first_key, [75] is_empty, [76] has_space, [79:77] zero
    output logic [ssq_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    localparam int SW = $clog2(SLOT_COUNT + 1);
    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [SW-1:0] NONE = SW'(SLOT_COUNT);

    ssq_pkg::t_state r_state, n_state;

    logic                 r_req, n_req;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [SW-1:0]        r_idx, n_idx;
    logic [SW-1:0]        r_prev, n_prev;
    logic [SW-1:0]        r_cur, n_cur;
    logic [SW-1:0]        r_act_head, n_act_head;
    logic [SW-1:0]        r_free_head, n_free_head;
    logic [KEY_WIDTH-1:0] r_head_key, n_head_key;
    logic                 r_ok, n_ok;
    logic [SW-1:0]        r_slot, n_slot;
    logic [KEY_WIDTH-1:0] r_pkey, n_pkey;
    logic                 r_out_valid, n_out_valid;
    logic [ssq_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic [KEY_WIDTH-1:0] r_key_mem [SLOT_COUNT];
    logic [KEY_WIDTH-1:0] r_kdata;
    logic                 key_we;
    logic [SW-1:0]        key_raddr;

    logic                 link_we;
    logic [SW-1:0]        link_waddr;
    logic [SW-1:0]        link_wdata;
    logic [SW-1:0]        link_raddr;
    logic [SW-1:0]        link_rdata;

    logic s_accept;
    logic out_free;
    logic key_less;
    logic nxt_valid;
    logic head_valid;
    logic free_valid;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign key_less   = r_key < r_kdata;
    assign nxt_valid  = link_rdata < NONE;
    assign head_valid = r_act_head < NONE;
    assign free_valid = r_free_head < NONE;

    ssq_link_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[r_free_head[IW-1:0]] <= r_key;
        end
        r_kdata <= r_key_mem[key_raddr[IW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser == ssq_pkg::REQ_POP) begin
                        n_state = head_valid ? ssq_pkg::ST_POP_RD : ssq_pkg::ST_DONE;
                    end else begin
                        n_state = free_valid ? ssq_pkg::ST_CLAIM : ssq_pkg::ST_DONE;
                    end
                end
            end
            ssq_pkg::ST_CLAIM:  n_state = ssq_pkg::ST_FREE;
            ssq_pkg::ST_FREE: begin
                n_state = (r_cur < NONE) ? ssq_pkg::ST_WALK : ssq_pkg::ST_LINK_A;
            end
            ssq_pkg::ST_WALK: begin
                if (key_less || !nxt_valid) begin
                    n_state = ssq_pkg::ST_LINK_A;
                end
            end
            ssq_pkg::ST_LINK_A: n_state = ssq_pkg::ST_LINK_B;
            ssq_pkg::ST_LINK_B: n_state = ssq_pkg::ST_DONE;
            ssq_pkg::ST_POP_RD: n_state = ssq_pkg::ST_POP_WR;
            ssq_pkg::ST_POP_WR: begin
                n_state = nxt_valid ? ssq_pkg::ST_POP_HK : ssq_pkg::ST_DONE;
            end
            ssq_pkg::ST_POP_HK: n_state = ssq_pkg::ST_DONE;
            ssq_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ssq_pkg::ST_IDLE;
                end
            end
            default: n_state = ssq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_key       = r_key;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_act_head  = r_act_head;
        n_free_head = r_free_head;
        n_head_key  = r_head_key;
        n_ok        = r_ok;
        n_slot      = r_slot;
        n_pkey      = r_pkey;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        key_we      = 1'b0;
        key_raddr   = r_cur;
        link_we     = 1'b0;
        link_waddr  = r_idx;
        link_wdata  = r_cur;
        link_raddr  = r_cur;
        o_s_tready  = 1'b0;

        case (r_state)
            ssq_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (s_accept) begin
                    n_req  = i_s_tuser;
                    n_key  = KEY_WIDTH'(i_s_tdata);
                    n_ok   = 1'b0;
                    n_slot = NONE;
                    n_pkey = '0;
                end
            end
            ssq_pkg::ST_CLAIM: begin
                key_we     = 1'b1;
                link_raddr = r_free_head;
                n_idx      = r_free_head;
                n_prev     = NONE;
                n_cur      = r_act_head;
            end
            ssq_pkg::ST_FREE: begin
                n_free_head = link_rdata;
                link_raddr  = r_cur;
                key_raddr   = r_cur;
            end
            ssq_pkg::ST_WALK: begin
                if (!key_less) begin
                    n_prev     = r_cur;
                    n_cur      = link_rdata;
                    link_raddr = link_rdata;
                    key_raddr  = link_rdata;
                end
            end
            ssq_pkg::ST_LINK_A: begin
                if (r_prev < NONE) begin
                    link_we    = 1'b1;
                    link_waddr = r_prev;
                    link_wdata = r_idx;
                end else begin
                    n_act_head = r_idx;
                    n_head_key = r_key;
                end
            end
            ssq_pkg::ST_LINK_B: begin
                link_we    = 1'b1;
                link_waddr = r_idx;
                link_wdata = r_cur;
                n_ok       = 1'b1;
                n_slot     = r_idx;
            end
            ssq_pkg::ST_POP_RD: begin
                link_raddr = r_act_head;
                key_raddr  = r_act_head;
                n_idx      = r_act_head;
            end
            ssq_pkg::ST_POP_WR: begin
                n_act_head  = link_rdata;
                link_we     = 1'b1;
                link_waddr  = r_idx;
                link_wdata  = r_free_head;
                n_free_head = r_idx;
                n_pkey      = r_kdata;
                n_ok        = 1'b1;
                n_slot      = r_idx;
                key_raddr   = link_rdata;
            end
            ssq_pkg::ST_POP_HK: begin
                n_head_key = r_kdata;
            end
            ssq_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {
                        3'b000,
                        free_valid,
                        !head_valid,
                        head_valid ? ssq_pkg::KEY_FIELD_W'(r_head_key)
                                   : ssq_pkg::KEY_FIELD_W'(0),
                        ssq_pkg::SLOT_FIELD_W'(r_act_head),
                        ssq_pkg::KEY_FIELD_W'(r_pkey),
                        ssq_pkg::SLOT_FIELD_W'(r_slot),
                        r_ok
                    };
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssq_pkg::ST_IDLE;
            r_act_head  <= NONE;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_act_head  <= n_act_head;
            r_free_head <= n_free_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_head_key <= n_head_key;
        r_ok       <= n_ok;
        r_slot     <= n_slot;
        r_pkey     <= n_pkey;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // the active and free list heads are never the same slot
    a_heads_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act_head < NONE) && (r_free_head < NONE) |-> r_act_head != r_free_head)
        else $error("active and free list share a head slot");

    // the walk only visits linked entries
    a_walk_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssq_pkg::ST_WALK |-> r_cur < NONE)
        else $error("walk on an empty link");

    // after a link-in the list holds an entry
    a_link_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssq_pkg::ST_LINK_B |=> r_act_head < NONE)
        else $error("list empty after insert");

    // a pop result is only built from a pop request
    a_pop_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssq_pkg::ST_POP_WR |-> r_req == ssq_pkg::REQ_POP)
        else $error("pop path entered on insert");

endmodule

// ===== tb/sv/slot_queue_sb_pkg.sv =====
package slot_queue_sb_pkg;

    import ssq_pkg::*;

    localparam int NSLOT = SLOT_COUNT_DEF;
    localparam logic [SLOT_FIELD_W-1:0] NO_SLOT = SLOT_FIELD_W'(NSLOT);

    // result beat, lowest bit last
    typedef struct packed {
        logic [2:0]              pad;
        logic                    has_space;
        logic                    is_empty;
        logic [KEY_FIELD_W-1:0]  first_key;
        logic [SLOT_FIELD_W-1:0] first_slot;
        logic [KEY_FIELD_W-1:0]  popped_key;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    ok;
    } t_slot_result;

    class slot_queue_scoreboard;
        logic [KEY_FIELD_W-1:0]  key_mem  [NSLOT];
        logic [SLOT_FIELD_W-1:0] link_mem [NSLOT];
        logic [SLOT_FIELD_W-1:0] busy_head;
        logic [SLOT_FIELD_W-1:0] idle_head;
        t_slot_result            awaited_q[$];
        int depth, peak_depth, n_insert, n_pop, n_full, n_empty, n_checked, n_errors;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                key_mem[i]  = '0;
                link_mem[i] = SLOT_FIELD_W'(i + 1);
            end
            busy_head = NO_SLOT;
            idle_head = '0;
        endfunction

        function int outstanding();
            return awaited_q.size();
        endfunction

        // update the shadow lists for one accepted request and queue its result
        function void note_request(logic req, logic [KEY_FIELD_W-1:0] key);
            t_slot_result            r;
            logic [SLOT_FIELD_W-1:0] idx;
            logic [SLOT_FIELD_W-1:0] prev;
            logic [SLOT_FIELD_W-1:0] cur;
            int                      steps;
            r      = '0;
            r.slot = NO_SLOT;
            if (req == REQ_INSERT) begin
                n_insert++;
                if (idle_head == NO_SLOT) begin
                    n_full++;
                end else begin
                    idx          = idle_head;
                    key_mem[idx] = key;
                    idle_head    = link_mem[idx];
                    prev         = NO_SLOT;
                    cur          = busy_head;
                    steps        = 0;
                    // stop at first strictly greater key: ties keep arrival order
                    while (cur != NO_SLOT && steps < NSLOT) begin
                        if (key < key_mem[cur])
                            break;
                        prev = cur;
                        cur  = link_mem[cur];
                        steps++;
                    end
                    if (prev == NO_SLOT)
                        busy_head = idx;
                    else
                        link_mem[prev] = idx;
                    link_mem[idx] = cur;
                    r.ok   = 1'b1;
                    r.slot = idx;
                    depth++;
                    if (depth > peak_depth)
                        peak_depth = depth;
                end
            end else begin
                n_pop++;
                if (busy_head == NO_SLOT) begin
                    n_empty++;
                end else begin
                    idx           = busy_head;
                    busy_head     = link_mem[idx];
                    link_mem[idx] = idle_head;
                    idle_head     = idx;
                    r.ok          = 1'b1;
                    r.slot        = idx;
                    r.popped_key  = key_mem[idx];
                    depth--;
                end
            end
            r.is_empty   = (busy_head == NO_SLOT);
            r.first_slot = busy_head;
            if (!r.is_empty)
                r.first_key = key_mem[busy_head];
            r.has_space  = (idle_head != NO_SLOT);
            awaited_q.push_back(r);
        endfunction

        task report(string what, logic [63:0] got_v, logic [63:0] want_v);
            n_errors++;
            if (n_errors <= 40)
                $display("MISMATCH beat %0d %s: got %0h want %0h",
                         n_checked, what, got_v, want_v);
        endtask

        task compare(string what, logic [63:0] got_v, logic [63:0] want_v);
            if (got_v !== want_v)
                report(what, got_v, want_v);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] beat);
            t_slot_result got;
            t_slot_result want;
            got = beat;
            if (awaited_q.size() == 0) begin
                report("beat with nothing pending", 64'(beat), '0);
                return;
            end
            want = awaited_q.pop_front();
            n_checked++;
            compare("ok",         64'(got.ok),         64'(want.ok));
            compare("slot",       64'(got.slot),       64'(want.slot));
            compare("popped_key", 64'(got.popped_key), 64'(want.popped_key));
            compare("first_slot", 64'(got.first_slot), 64'(want.first_slot));
            compare("first_key",  64'(got.first_key),  64'(want.first_key));
            compare("is_empty",   64'(got.is_empty),   64'(want.is_empty));
            compare("has_space",  64'(got.has_space),  64'(want.has_space));
            compare("pad",        64'(got.pad),        64'(want.pad));
        endtask
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ssq_pkg::*;
    import slot_queue_sb_pkg::*;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    slot_queue_scoreboard sb;
    bit send_quiet;
    bit recv_quiet;
    int beats_out;

    always #5 clk = ~clk;

    sorted_slot_list_queue i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    task automatic send_req(logic req, logic [KEY_FIELD_W-1:0] key);
        int gap;
        if ($urandom_range(0, 24) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= key;
        do @(posedge clk); while (!s_tready);
        sb.note_request(req, key);
        @(negedge clk);
    endtask

    function automatic logic [KEY_FIELD_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0, 1:    return KEY_FIELD_W'($urandom_range(0, 7));
            2:       return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int   mode;
        int   len;
        int   n;
        logic req;
        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_req(REQ_POP,    32'h0);
        send_req(REQ_INSERT, 32'hFFFF_FFFF);
        send_req(REQ_INSERT, 32'h0000_0000);
        send_req(REQ_INSERT, 32'h8000_0000);
        send_req(REQ_INSERT, 32'h7FFF_FFFF);
        send_req(REQ_INSERT, 32'h8000_0000);
        send_req(REQ_INSERT, 32'hFFFF_FFFF);
        send_req(REQ_INSERT, 32'h0000_0000);
        repeat (9) send_req(REQ_POP, $urandom());

        // fill to full, drain past empty, then random insert/pop bursts
        n = 0;
        while (n < 450) begin
            if (n == 0) begin
                mode = 3;
                len  = 20;
            end else if (n == 20) begin
                mode = 4;
                len  = 20;
            end else begin
                mode = $urandom_range(0, 2);
                len  = $urandom_range(8, 30);
            end
            repeat (len) begin
                case (mode)
                    0:       req = ($urandom_range(0, 9) == 0) ? REQ_POP : REQ_INSERT;
                    1:       req = ($urandom_range(0, 9) == 0) ? REQ_INSERT : REQ_POP;
                    2:       req = $urandom_range(0, 1) ? REQ_POP : REQ_INSERT;
                    3:       req = REQ_INSERT;
                    default: req = REQ_POP;
                endcase
                send_req(req, pick_key());
                n++;
            end
        end
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Requests: %0d inserts (%0d refused as full), %0d pops (%0d on empty queue)",
                 sb.n_insert, sb.n_full, sb.n_pop, sb.n_empty);
        $display("Result beats checked: %0d, peak depth %0d, mismatches %0d",
                 sb.n_checked, sb.peak_depth, sb.n_errors);
        if (sb.n_errors == 0 && sb.outstanding() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 24) == 0)
                recv_quiet = !recv_quiet;
            gap = recv_quiet ? 0 : $urandom_range(0, 13);
            // one long stall so the block backs up into its input
            if (!held && beats_out == 60) begin
                gap  = 300;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
            beats_out++;
            @(negedge clk);
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results pending", sb.outstanding());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
